[src/wspc_pkg.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID controller package
// Shared constants, register codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wspc_pkg;

    localparam int HISTORY_DEPTH = 3;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DIV_W         = 64;
    localparam int CNT_W         = $clog2(DIV_W + 1);

    localparam logic [23:0]        SPEED_MAX  = 24'hFFFFFF;
    localparam logic [15:0]        TICKS_MAX  = 16'hFFFF;
    localparam logic signed [49:0] BIAS_Q28   = 50'sd40265318;
    localparam logic signed [49:0] Q28_ONE    = 50'sd268435456;
    localparam logic signed [32:0] STEER_COEF = 33'sd7864;
    localparam logic signed [32:0] D31_ONE    = 33'sh080000000;
    localparam logic [63:0]        NUM_HALL   = 64'd128500 << 47;
    localparam logic [63:0]        NUM_DIST   = 64'd1285 << 47;
    localparam logic signed [32:0] K_DIST     = 33'sd10000;
    localparam logic signed [32:0] K_HUNDRED  = 33'sd100;
    localparam logic signed [32:0] RECIP_100  = 33'sd42949673;
    localparam logic signed [32:0] HIST_HI    = 33'((64'd1 << 24) / 64'(HISTORY_DEPTH));
    localparam logic [3:0]         HIST_R     = 4'((64'd1 << 24) % 64'(HISTORY_DEPTH));
    localparam logic signed [32:0] HIST_RECIP =
        33'(((64'd1 << 31) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_KP     = 3'd1;
    localparam logic [2:0] REG_KI     = 3'd2;
    localparam logic [2:0] REG_KD     = 3'd3;
    localparam logic [2:0] REG_ENABLE = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;

    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_BACK = 2'd2;
    localparam logic       CMD_HALL  = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H_MUL,
        ST_H_DIV1,
        ST_H_MUL2,
        ST_H_DIV2,
        ST_T_MUL,
        ST_T_MUL2,
        ST_T_DIV,
        ST_P_ERR,
        ST_P_DIV1,
        ST_P_INT,
        ST_P_M1,
        ST_P_M2,
        ST_P_M3,
        ST_P_M4,
        ST_P_DIV3,
        ST_P_DIV3B,
        ST_P_DIV3C,
        ST_P_SUM,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[src/wheel_speed_pid_controller_top.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID controller
// Hall-event speed and distance estimation, speed decay and PID drive step.
// ----------------------------------------------------------------------------
// A hall event multiplies, divides for speed (skipped on a zero capture difference),
// multiplies and divides for distance; a tick multiplies twice, divides unless no
// magnet is counted yet, and may add the PID step. Divisions use the shared divider.
// Throughput: one request at a time; the next is taken the cycle after the result is
// loaded into the output register, which holds while the previous result waits.
// Reset: aresetn synchronous active low resets sequencer, status and config registers.
`default_nettype none

module wheel_speed_pid_controller_top
    import wspc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // capture_time[31:0], steering[47:32]
    input  wire logic [0:0]  s_tuser,   // cmd[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // speed[23:0], distance_total[55:24],
                                        // pwm_compare[71:56]
    output logic      [0:0]  m_tuser,   // pwm_update[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    state_t state_reg, state_next;

    logic [23:0]        target_reg;
    logic signed [15:0] kp_reg, ki_reg, kd_reg;
    logic               enable_reg;
    logic [1:0]         mode_reg;

    logic [31:0]        last_cap_reg, last_cap_next;
    logic [23:0]        speed_reg, speed_next;
    logic [15:0]        ticks_reg, ticks_next;
    logic [31:0]        distance_reg, distance_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [24:0] hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [15:0]        cmp_reg, cmp_next;

    logic               cmd_reg, cmd_next;
    logic [31:0]        diff_reg, diff_next;
    logic [31:0]        d31_reg, d31_next;
    logic signed [24:0] err_reg, err_next;
    logic signed [25:0] change_reg, change_next;
    logic signed [31:0] itry_reg, itry_next;
    logic signed [49:0] acc_reg, acc_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [27:0]        part_reg, part_next;
    logic               dneg_reg, dneg_next;
    logic               prod_en;
    logic signed [32:0] mul_a, mul_b;
    logic               upd_reg, upd_next;
    logic               hist_we;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [71:0]        m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic               div_wait_reg, div_wait_next;
    logic               div_start, div_busy, div_done;
    logic [DIV_W-1:0]   div_num, div_den, div_quot;

    logic signed [32:0] steer_prod;
    logic signed [24:0] err_calc;
    logic [24:0]        err_abs;
    logic signed [24:0] q100_s;
    logic signed [33:0] isum;
    logic signed [65:0] prod_abs;
    logic [27:0]        part_calc;
    logic [44:0]        scaled;
    logic [SLOT_W-1:0]  slot_cur;
    logic               is_div_state;
    logic               cfg_we;

    wspc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            kp_reg     <= 16'sd410;
            ki_reg     <= 16'sd819;
            kd_reg     <= '0;
            enable_reg <= 1'b0;
            mode_reg   <= '0;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_TARGET: target_reg <= pwdata[23:0];
                REG_KP:     kp_reg     <= pwdata[15:0];
                REG_KI:     ki_reg     <= pwdata[15:0];
                REG_KD:     kd_reg     <= pwdata[15:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_MODE:   mode_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_TARGET: prdata = {8'd0, target_reg};
            REG_KP:     prdata = {16'd0, kp_reg};
            REG_KI:     prdata = {16'd0, ki_reg};
            REG_KD:     prdata = {16'd0, kd_reg};
            REG_ENABLE: prdata = {31'd0, enable_reg};
            REG_MODE:   prdata = {30'd0, mode_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_cap_reg <= '0;
            speed_reg    <= '0;
            ticks_reg    <= '0;
            distance_reg <= '0;
            integ_reg    <= '0;
            slot_reg     <= '0;
            cmp_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            div_wait_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            last_cap_reg <= last_cap_next;
            speed_reg    <= speed_next;
            ticks_reg    <= ticks_next;
            distance_reg <= distance_next;
            integ_reg    <= integ_next;
            slot_reg     <= slot_next;
            cmp_reg      <= cmp_next;
            m_tvalid_reg <= m_tvalid_next;
            div_wait_reg <= div_wait_next;
            if (hist_we) begin
                hist_reg[slot_cur] <= err_calc;
            end
        end
        cmd_reg     <= cmd_next;
        diff_reg    <= diff_next;
        d31_reg     <= d31_next;
        err_reg     <= err_next;
        change_reg  <= change_next;
        itry_reg    <= itry_next;
        acc_reg     <= acc_next;
        part_reg    <= part_next;
        dneg_reg    <= dneg_next;
        upd_reg     <= upd_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (prod_en) begin
            prod_reg <= prod_next;
        end
    end

    assign steer_prod = 33'(signed'(s_tdata[47:32])) * STEER_COEF;
    assign err_calc   = signed'({1'b0, target_reg}) - signed'({1'b0, speed_reg});
    assign err_abs    = err_reg[24] ? 25'(-err_reg) : 25'(err_reg);
    assign q100_s     = err_reg[24] ? -signed'(prod_reg[56:32]) : signed'(prod_reg[56:32]);
    assign isum       = 34'(integ_reg) + 34'(q100_s);
    assign prod_abs   = prod_reg[65] ? -prod_reg : prod_reg;
    assign part_calc  = 28'(prod_abs[46:24]) * 28'(HIST_R) + 28'(prod_abs[23:0]);
    assign scaled     = {acc_reg[28:0], 16'd0} - 45'(acc_reg[28:0]);
    assign slot_cur   = (int'(slot_reg) >= HISTORY_DEPTH) ? '0 : slot_reg;
    assign prod_next  = mul_a * mul_b;

    assign is_div_state = (state_reg == ST_H_DIV1) || (state_reg == ST_H_DIV2) ||
                          (state_reg == ST_T_DIV);

    always_comb begin
        state_next    = state_reg;
        last_cap_next = last_cap_reg;
        speed_next    = speed_reg;
        ticks_next    = ticks_reg;
        distance_next = distance_reg;
        integ_next    = integ_reg;
        slot_next     = slot_reg;
        cmp_next      = cmp_reg;
        cmd_next      = cmd_reg;
        diff_next     = diff_reg;
        d31_next      = d31_reg;
        err_next      = err_reg;
        change_next   = change_reg;
        itry_next     = itry_reg;
        acc_next      = acc_reg;
        part_next     = part_reg;
        dneg_next     = dneg_reg;
        upd_next      = upd_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_wait_next = div_wait_reg;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;
        mul_a         = '0;
        mul_b         = '0;
        prod_en       = 1'b0;
        hist_we       = 1'b0;
        s_tready      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (is_div_state) begin
            if (!div_wait_reg) begin
                div_start     = 1'b1;
                div_wait_next = 1'b1;
            end else if (div_done) begin
                div_wait_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next  = s_tuser[0];
                    diff_next = last_cap_reg - s_tdata[31:0];
                    d31_next  = 32'(D31_ONE - steer_prod);
                    if (s_tuser[0] == CMD_HALL) begin
                        last_cap_next = s_tdata[31:0];
                        state_next    = ST_H_MUL;
                    end else begin
                        state_next    = ST_T_MUL;
                    end
                end
            end
            ST_H_MUL: begin
                mul_a   = signed'({1'b0, diff_reg});
                mul_b   = signed'({1'b0, d31_reg});
                prod_en = 1'b1;
                if (diff_reg == '0) begin
                    speed_next = SPEED_MAX;
                    state_next = ST_H_MUL2;
                end else begin
                    state_next = ST_H_DIV1;
                end
            end
            ST_H_DIV1: begin
                div_num = NUM_HALL;
                div_den = prod_reg[63:0];
                if (div_wait_reg && div_done) begin
                    speed_next = (div_quot > 64'(SPEED_MAX)) ? SPEED_MAX : div_quot[23:0];
                    state_next = ST_H_MUL2;
                end
            end
            ST_H_MUL2: begin
                mul_a      = K_DIST;
                mul_b      = signed'({1'b0, d31_reg});
                prod_en    = 1'b1;
                state_next = ST_H_DIV2;
            end
            ST_H_DIV2: begin
                div_num = NUM_DIST;
                div_den = prod_reg[63:0];
                if (div_wait_reg && div_done) begin
                    distance_next = distance_reg + div_quot[31:0];
                    ticks_next    = '0;
                    upd_next      = 1'b0;
                    state_next    = ST_DONE;
                end
            end
            ST_T_MUL: begin
                mul_a      = K_HUNDRED;
                mul_b      = signed'({17'd0, ticks_reg});
                prod_en    = 1'b1;
                state_next = ST_T_MUL2;
            end
            ST_T_MUL2: begin
                mul_a      = prod_reg[32:0];
                mul_b      = signed'({1'b0, d31_reg});
                prod_en    = 1'b1;
                state_next = ST_T_DIV;
            end
            ST_T_DIV: begin
                div_num = NUM_DIST;
                div_den = prod_reg[63:0];
                if (ticks_reg == '0 || (div_wait_reg && div_done)) begin
                    if (ticks_reg == '0) begin
                        div_start     = 1'b0;
                        div_wait_next = 1'b0;
                    end else if (div_quot < 64'(speed_reg)) begin
                        speed_next = div_quot[23:0];
                    end
                    if (ticks_reg != TICKS_MAX) begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                    if (enable_reg && (mode_reg == MODE_FWD || mode_reg == MODE_BACK)) begin
                        state_next = ST_P_ERR;
                    end else begin
                        upd_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_P_ERR: begin
                err_next    = err_calc;
                change_next = 26'(err_calc) - 26'(hist_reg[slot_cur]);
                hist_we     = 1'b1;
                slot_next   = (int'(slot_cur) == HISTORY_DEPTH - 1) ? '0 : slot_cur + 1'b1;
                state_next  = ST_P_DIV1;
            end
            ST_P_DIV1: begin
                mul_a      = 33'(err_abs);
                mul_b      = RECIP_100;
                prod_en    = 1'b1;
                state_next = ST_P_INT;
            end
            ST_P_INT: begin
                if (isum > 34'sh07FFFFFFF) begin
                    itry_next = 32'sh7FFFFFFF;
                end else if (isum < -34'sh080000000) begin
                    itry_next = 32'sh80000000;
                end else begin
                    itry_next = isum[31:0];
                end
                state_next = ST_P_M1;
            end
            ST_P_M1: begin
                mul_a      = 33'(kp_reg);
                mul_b      = 33'(err_reg);
                prod_en    = 1'b1;
                state_next = ST_P_M2;
            end
            ST_P_M2: begin
                acc_next   = BIAS_Q28 + prod_reg[49:0];
                mul_a      = 33'(ki_reg);
                mul_b      = 33'(itry_reg);
                prod_en    = 1'b1;
                state_next = ST_P_M3;
            end
            ST_P_M3: begin
                acc_next   = acc_reg + prod_reg[49:0];
                mul_a      = 33'(change_reg);
                mul_b      = K_HUNDRED;
                prod_en    = 1'b1;
                state_next = ST_P_M4;
            end
            ST_P_M4: begin
                mul_a      = 33'(kd_reg);
                mul_b      = prod_reg[32:0];
                prod_en    = 1'b1;
                state_next = ST_P_DIV3;
            end
            ST_P_DIV3: begin
                mul_a      = 33'(prod_abs[46:24]);
                mul_b      = HIST_HI;
                prod_en    = 1'b1;
                part_next  = part_calc;
                dneg_next  = prod_reg[65];
                state_next = ST_P_DIV3B;
            end
            ST_P_DIV3B: begin
                acc_next   = dneg_reg ? acc_reg - 50'(prod_reg[47:0])
                                      : acc_reg + 50'(prod_reg[47:0]);
                mul_a      = 33'(part_reg);
                mul_b      = HIST_RECIP;
                prod_en    = 1'b1;
                state_next = ST_P_DIV3C;
            end
            ST_P_DIV3C: begin
                acc_next   = dneg_reg ? acc_reg - 50'(prod_reg[58:31])
                                      : acc_reg + 50'(prod_reg[58:31]);
                state_next = ST_P_SUM;
            end
            ST_P_SUM: begin
                if (acc_reg < 0) begin
                    cmp_next = '0;
                end else if (acc_reg > Q28_ONE) begin
                    cmp_next = 16'hFFFF;
                end else begin
                    integ_next = itry_reg;
                    cmp_next   = scaled[43:28];
                end
                upd_next   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {cmp_reg, distance_reg, speed_reg};
                    m_tuser_next  = upd_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> is_div_state)
        else $error("divider running outside a division step");

    a_distance_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_H_DIV2) |=> $stable(distance_reg))
        else $error("distance changed outside a hall event");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(slot_reg) < HISTORY_DEPTH)
        else $error("history slot out of range");

    a_ready_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy && !div_wait_reg)
        else $error("request taken while divider busy");

endmodule

`default_nettype wire

[src/wspc_div.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID controller divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wspc_div
    import wspc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] num,
    input  wire logic [DIV_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic      [DIV_W-1:0] quot
);

    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[DIV_W-1:0], quot_reg[DIV_W-1]};
        if (start) begin
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
            cnt_next  = CNT_W'(DIV_W);
        end else if (cnt_reg != '0) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next  = rem_sh - {1'b0, den_reg};
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

[test/tb_wheel_speed_pid_controller_top.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID controller testbench
// Streams hall events and control ticks through the block with random gaps
// and stalls, predicts speed, distance and the PID compare value in a local
// fixed-point model, and compares every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wheel_speed_pid_controller_top
    import wspc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] capture;
        logic [15:0] steer;
    } request_t;

    typedef struct packed {
        logic [23:0] speed;
        logic [31:0] distance;
        logic [15:0] pwm;
        logic        upd;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wheel_speed_pid_controller_top u_top (.*);

    always #1 aclk = ~aclk;

    // configuration copy
    logic [23:0]        cfg_target;
    logic signed [15:0] cfg_kp, cfg_ki, cfg_kd;
    logic               cfg_en;
    logic [1:0]         cfg_mode;
    // predictor state
    logic [31:0]        prev_capture;
    logic [23:0]        speed_q;
    logic [15:0]        tick_count;
    logic [31:0]        dist_q;
    logic signed [63:0] integ_acc;
    logic signed [63:0] err_hist [HISTORY_DEPTH];
    int                 hist_idx;
    logic [15:0]        compare_q;

    request_t request_queue[$];
    outcome_t outcome_queue[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  feeding_done = 0;
    bit  hold_sender = 0;

    function automatic logic [63:0] steer_divisor(logic [15:0] s);
        logic signed [63:0] sv;
        sv = $signed(s);
        return 64'(64'sd2147483648 - 64'sd7864 * sv);
    endfunction

    function automatic void predict_pid();
        logic signed [63:0] err, nxt, chg, dterm, total;
        int slot;
        err = $signed({40'd0, cfg_target}) - $signed({40'd0, speed_q});
        nxt = integ_acc + err / 100;
        if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
        if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
        slot = hist_idx;
        chg = err - err_hist[slot];
        err_hist[slot] = err;
        hist_idx = (slot + 1) % HISTORY_DEPTH;
        dterm = (64'(cfg_kd) * chg * 100) / HISTORY_DEPTH;
        total = 64'sd40265318 + 64'(cfg_kp) * err + 64'(cfg_ki) * nxt + dterm;
        if (total < 0) compare_q = 16'd0;
        else if (total > 64'sd268435456) compare_q = 16'hFFFF;
        else begin
            integ_acc = nxt;
            compare_q = 16'((64'(total) * 64'd65535) >> 28);
        end
    endfunction

    function automatic outcome_t predict_outcome(request_t r);
        outcome_t o;
        logic [63:0] d31, q;
        logic [31:0] diff;
        logic [127:0] den;
        d31 = steer_divisor(r.steer);
        o.upd = 1'b0;
        if (r.cmd == CMD_HALL) begin
            diff = prev_capture - r.capture;
            prev_capture = r.capture;
            if (diff == 0) speed_q = SPEED_MAX;
            else begin
                den = 128'(diff) * 128'(d31);
                q = 64'((128'd128500 << 47) / den);
                speed_q = (q > 64'(SPEED_MAX)) ? SPEED_MAX : q[23:0];
            end
            tick_count = 16'd0;
            dist_q = dist_q + 32'((64'd1285 << 47) / (64'd10000 * d31));
        end else begin
            if (tick_count > 0) begin
                den = 128'd100 * 128'(tick_count) * 128'(d31);
                q = 64'((128'd1285 << 47) / den);
                if (q > 64'(SPEED_MAX)) q = 64'(SPEED_MAX);
                if (q[31:0] < {8'd0, speed_q}) speed_q = q[23:0];
            end
            if (tick_count != TICKS_MAX) tick_count = tick_count + 1'b1;
            if (cfg_en && (cfg_mode == MODE_FWD || cfg_mode == MODE_BACK)) begin
                predict_pid();
                o.upd = 1'b1;
            end
        end
        o.speed = speed_q;
        o.distance = dist_q;
        o.pwm = compare_q;
        return o;
    endfunction

    // driver
    int send_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                outcome_queue.push_back(predict_outcome(
                    request_t'({s_tuser, s_tdata[31:0], s_tdata[47:32]})));
                void'(request_queue.pop_front());
                send_wait <= $urandom_range(0, 14);
                s_tvalid <= 1'b0;
            end else if (!s_tvalid && send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else if (!s_tvalid && !hold_sender && request_queue.size() > 0) begin
                s_tuser <= request_queue[0].cmd;
                s_tdata <= {request_queue[0].steer, request_queue[0].capture};
                s_tvalid <= 1'b1;
            end
        end
    end

    // monitor
    int recv_wait = 0;
    always @(posedge aclk) begin
        outcome_t got, exp_o;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[23:0], m_tdata[55:24], m_tdata[71:56], m_tuser[0]};
                if (outcome_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_o = outcome_queue.pop_front();
                    if (got.speed !== exp_o.speed) begin
                        $display("%0t: speed exp %h got %h", $time, exp_o.speed, got.speed);
                        errors++;
                    end
                    if (got.distance !== exp_o.distance) begin
                        $display("%0t: distance exp %h got %h", $time, exp_o.distance,
                                 got.distance);
                        errors++;
                    end
                    if (got.pwm !== exp_o.pwm) begin
                        $display("%0t: pwm exp %h got %h", $time, exp_o.pwm, got.pwm);
                        errors++;
                    end
                    if (got.upd !== exp_o.upd) begin
                        $display("%0t: upd exp %h got %h", $time, exp_o.upd, got.upd);
                        errors++;
                    end
                end
                recv_wait = $urandom_range(0, 14);
                m_tready <= (recv_wait == 0);
            end else if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                m_tready <= (recv_wait == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else if (aresetn && (request_queue.size() > 0 || outcome_queue.size() > 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_TARGET: cfg_target = value[23:0];
            REG_KP:     cfg_kp = value[15:0];
            REG_KI:     cfg_ki = value[15:0];
            REG_KD:     cfg_kd = value[15:0];
            REG_ENABLE: cfg_en = value[0];
            REG_MODE:   cfg_mode = value[1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (request_queue.size() > 0 || s_tvalid || outcome_queue.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic push_item(logic cmd, logic [31:0] cap, logic [15:0] st);
        request_t r;
        r.cmd = cmd; r.capture = cap; r.steer = st;
        request_queue.push_back(r);
    endtask

    function automatic logic [15:0] rand_steer();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count, logic [31:0] cap_start);
        logic [31:0] cap;
        cap = cap_start;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: cap = cap;
                    1: cap = 32'($urandom);
                    2: cap = cap - $urandom_range(1, 40);
                    default: cap = cap - $urandom_range(2000, 400000);
                endcase
                push_item(CMD_HALL, cap, rand_steer());
            end else begin
                push_item(~CMD_HALL, 32'($urandom), rand_steer());
            end
        end
    endtask

    initial begin
        cfg_target = 0; cfg_kp = 410; cfg_ki = 819; cfg_kd = 0; cfg_en = 0; cfg_mode = 0;
        prev_capture = 0; speed_q = 0; tick_count = 0; dist_q = 0; integ_acc = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++) err_hist[i] = 0;
        hist_idx = 0; compare_q = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, control off
        push_item(~CMD_HALL, 32'hFFFFFFFF, 16'h0000);
        push_item(CMD_HALL, 32'h00000000, 16'h0000);
        push_item(CMD_HALL, 32'hFFFFFFFF, 16'h7FFF);
        push_item(CMD_HALL, 32'hFFFF0000, 16'h8000);
        push_item(~CMD_HALL, 32'h0, 16'h7FFF);
        push_item(~CMD_HALL, 32'h0, 16'h8000);
        push_item(~CMD_HALL, 32'h0, 16'h0000);
        drain();
        write_reg(REG_TARGET, 32'h00030000);
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_MODE, 32'd1);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        push_item(CMD_HALL, 32'hFFF00000, 16'h1234);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        drain();
        write_reg(REG_KP, 32'h00007FFF);
        write_reg(REG_KI, 32'h00008000);
        write_reg(REG_KD, 32'h00007FFF);
        write_reg(REG_TARGET, 32'h00FFFFFF);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        push_item(CMD_HALL, 32'hFFF00000, 16'h0);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        drain();
        write_reg(REG_MODE, 32'd2);
        write_reg(REG_KP, 32'h0000FFFF);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        drain();
        write_reg(REG_MODE, 32'd3);
        push_item(~CMD_HALL, 32'h0, 16'h0);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 13; ph++) begin
            write_reg(REG_TARGET, (ph % 4 == 0) ? 32'h0 : (ph % 4 == 1) ? 32'hFFFFFF
                                  : {8'd0, 24'($urandom_range(0, 24'h0A0000))});
            write_reg(REG_KP, (ph == 1) ? 32'h8000 : (ph == 2) ? 32'h7FFF
                              : 32'($urandom_range(0, 2000)));
            write_reg(REG_KI, (ph == 3) ? 32'h8000 : 32'($urandom));
            write_reg(REG_KD, (ph == 4) ? 32'h7FFF : $urandom_range(0, 1) ? 32'h0
                              : 32'($urandom));
            write_reg(REG_ENABLE, (ph % 5 == 4) ? 32'd0 : 32'd1);
            write_reg(REG_MODE, (ph % 6 == 5) ? 32'($urandom_range(0, 3))
                                : 32'($urandom_range(1, 2)));
            random_phase(150, 32'($urandom));
            if (ph == 6) begin
                while (request_queue.size() > 75) @(posedge aclk);
                hold_sender = 1;
                @(posedge aclk);
                while (s_tvalid || outcome_queue.size() > 0) @(posedge aclk);
                hold_sender = 0;
            end
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/wspc_pkg.sv
src/wspc_div.sv
src/wheel_speed_pid_controller_top.sv
test/tb_wheel_speed_pid_controller_top.sv
